// File: design/vertex_rotate_project_defines.svh
// Assertion macros shared by the vertex rotate and project block.
// Depends on nothing; the including module supplies clk and rst_n.
`ifndef VERTEX_ROTATE_PROJECT_DEFINES_SVH
`define VERTEX_ROTATE_PROJECT_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define VRP_ASSERT_NOW(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define VRP_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

// File: design/vrp_pkg.sv
// Package for the vertex rotate and project block: widths, constants, types.
// Used by vrp_sine, vrp_div_cell and vertex_rotate_project; depends on nothing.
package vrp_pkg;

    // Field widths.
    localparam int VTX_W   = 15;
    localparam int ANGLE_W = 12;
    localparam int SCR_W   = 12;
    localparam int CTR_W   = 10;
    localparam int IDX_W   = 2;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] CFG_CENTER_X = 2'd0;
    localparam logic [IDX_W-1:0] CFG_CENTER_Y = 2'd1;
    localparam logic [CTR_W-1:0] CENTER_RESET = 10'd90;

    // Sine unit.
    localparam int QTR_W    = ANGLE_W - 2;
    localparam int T_SHIFT  = 5;
    localparam int T_W      = QTR_W + 1 + T_SHIFT;
    localparam int TRIG_W   = 16;
    localparam int P_W      = 31;
    localparam int PROD_W   = P_W + T_W;
    localparam int Q_FRAC   = 15;
    localparam int POLY_N   = 4;
    localparam int SINE_LAT = POLY_N + 3;
    localparam logic [ANGLE_W-1:0] QUARTER_TURN = ANGLE_W'(1 << QTR_W);
    localparam logic [P_W-1:0] SIN_COEF [POLY_N+1] = '{
        31'd172272, 31'd5026995, 31'd85569306, 31'd693598668, 31'd1686629713
    };
    localparam logic [TRIG_W-1:0] TRIG_MAX = 16'd32767;

    // Rotation and projection.
    localparam int COORD_W = 32;
    localparam int ROT_W   = COORD_W + TRIG_W;
    localparam int NUM_W   = 38;
    localparam int DEN_W   = 34;
    localparam int NMAG_W  = NUM_W - 1;
    localparam int DMAG_W  = DEN_W - 1;
    localparam int Q_W     = 13;
    localparam int DSH_W   = DMAG_W + Q_W - 1;
    localparam int EYE_DISTANCE     = 30000;
    localparam int PROJECTION_SCALE = 50;
    localparam logic signed [NUM_W-1:0] SCALE_S = NUM_W'(PROJECTION_SCALE);
    localparam logic signed [DEN_W-1:0] EYE_Q15 = DEN_W'(longint'(EYE_DISTANCE) << Q_FRAC);
    localparam logic [Q_W-1:0] Q_LIMIT = Q_W'(1 << (Q_W - 1));

    // Sine stages, six rotation stages, numerator, magnitude, cells, output.
    localparam int PIPE_DEPTH = SINE_LAT + 6 + 2 + Q_W + 1;

    // One lane of the divider chain.
    typedef struct packed {
        logic [NMAG_W-1:0] rem;
        logic [DSH_W-1:0]  dsh;
        logic [Q_W-1:0]    quo;
        logic              neg;
        logic              sat;
        logic              zero;
    } div_lane_t;

endpackage

// File: design/vertex_rotate_project.sv
// Vertex rotate and project: a pipeline from input transfer to the screen result.
// Throughput one vertex per cycle; the whole pipeline holds while a result waits.
// The pipeline is made up of the seven-stage sine units, six rotation stages, two
// projection set-up stages, the 13-cell divider chain and the output register.
// Reset (rst_n low, asynchronous) empties the pipeline and sets both centres to 90.
// Depends on vrp_pkg, vrp_sine, vrp_div_cell and the assertion macro header.
`include "vertex_rotate_project_defines.svh"
module vertex_rotate_project (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [vrp_pkg::VTX_W-1:0]    vertex_x,
    input  logic signed [vrp_pkg::VTX_W-1:0]    vertex_y,
    input  logic signed [vrp_pkg::VTX_W-1:0]    vertex_z,
    input  logic [vrp_pkg::ANGLE_W-1:0]         angle_x,
    input  logic [vrp_pkg::ANGLE_W-1:0]         angle_y,
    input  logic [vrp_pkg::ANGLE_W-1:0]         angle_z,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [vrp_pkg::SCR_W-1:0]    screen_x,
    output logic signed [vrp_pkg::SCR_W-1:0]    screen_y,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [vrp_pkg::IDX_W-1:0]           cfg_index,
    input  logic [vrp_pkg::CTR_W-1:0]           cfg_data
);
    import vrp_pkg::*;

    // Pipeline control. Every stage moves together; a stalled result holds all.
    logic                  en;
    logic [PIPE_DEPTH-1:0] vld_reg;
    logic [CTR_W-1:0]      center_x_reg;
    logic [CTR_W-1:0]      center_y_reg;

    assign en        = !vld_reg[PIPE_DEPTH-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = vld_reg[PIPE_DEPTH-1];
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], in_valid};
        end
    end

    // Configuration registers; an index beyond the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= CENTER_RESET;
            center_y_reg <= CENTER_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_CENTER_X: center_x_reg <= cfg_data;
                CFG_CENTER_Y: center_y_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Six sine units; cosine is the sine a quarter turn further on.
    logic signed [TRIG_W-1:0] cx, sx, cy, sy, cz, sz;

    vrp_sine u_cx (.clk(clk), .en(en), .angle(ANGLE_W'(angle_x + QUARTER_TURN)), .value(cx));
    vrp_sine u_sx (.clk(clk), .en(en), .angle(angle_x), .value(sx));
    vrp_sine u_cy (.clk(clk), .en(en), .angle(ANGLE_W'(angle_y + QUARTER_TURN)), .value(cy));
    vrp_sine u_sy (.clk(clk), .en(en), .angle(angle_y), .value(sy));
    vrp_sine u_cz (.clk(clk), .en(en), .angle(ANGLE_W'(angle_z + QUARTER_TURN)), .value(cz));
    vrp_sine u_sz (.clk(clk), .en(en), .angle(angle_z), .value(sz));

    // The vertex waits alongside the sine units.
    logic signed [VTX_W-1:0] vx_dly_reg [SINE_LAT];
    logic signed [VTX_W-1:0] vy_dly_reg [SINE_LAT];
    logic signed [VTX_W-1:0] vz_dly_reg [SINE_LAT];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vx_dly_reg[0] <= vertex_x;
            vy_dly_reg[0] <= vertex_y;
            vz_dly_reg[0] <= vertex_z;
            for (int i = 1; i < SINE_LAT; i++)
            begin
                vx_dly_reg[i] <= vx_dly_reg[i-1];
                vy_dly_reg[i] <= vy_dly_reg[i-1];
                vz_dly_reg[i] <= vz_dly_reg[i-1];
            end
        end
    end

    // Rotation about x: products, then exact Q15 sums.
    logic signed [2*TRIG_W-2:0] m_vycx_reg, m_vzsx_reg, m_vzcx_reg, m_vysx_reg;
    logic signed [COORD_W-1:0]  x0_8_reg, x0_9_reg, y1_9_reg, z1_9_reg;
    logic signed [TRIG_W-1:0]   cy8_reg, sy8_reg, cz8_reg, sz8_reg;
    logic signed [TRIG_W-1:0]   cy9_reg, sy9_reg, cz9_reg, sz9_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_vycx_reg <= (2*TRIG_W-1)'(vy_dly_reg[SINE_LAT-1]) * (2*TRIG_W-1)'(cx);
            m_vzsx_reg <= (2*TRIG_W-1)'(vz_dly_reg[SINE_LAT-1]) * (2*TRIG_W-1)'(sx);
            m_vzcx_reg <= (2*TRIG_W-1)'(vz_dly_reg[SINE_LAT-1]) * (2*TRIG_W-1)'(cx);
            m_vysx_reg <= (2*TRIG_W-1)'(vy_dly_reg[SINE_LAT-1]) * (2*TRIG_W-1)'(sx);
            x0_8_reg   <= COORD_W'(vx_dly_reg[SINE_LAT-1]) <<< Q_FRAC;
            cy8_reg    <= cy;
            sy8_reg    <= sy;
            cz8_reg    <= cz;
            sz8_reg    <= sz;
            y1_9_reg   <= COORD_W'(m_vycx_reg) + COORD_W'(m_vzsx_reg);
            z1_9_reg   <= COORD_W'(m_vzcx_reg) - COORD_W'(m_vysx_reg);
            x0_9_reg   <= x0_8_reg;
            cy9_reg    <= cy8_reg;
            sy9_reg    <= sy8_reg;
            cz9_reg    <= cz8_reg;
            sz9_reg    <= sz8_reg;
        end
    end

    // Rotation about y, then about z: products, then sums rounded half up to Q15.
    logic signed [ROT_W-1:0]   p_x0cy_reg, p_z1sy_reg, p_z1cy_reg, p_x0sy_reg;
    logic signed [ROT_W-1:0]   q_x2cz_reg, q_y1sz_reg, q_y1cz_reg, q_x2sz_reg;
    logic signed [COORD_W-1:0] y1_10_reg, y1_11_reg, x2_11_reg, z2_11_reg;
    logic signed [COORD_W-1:0] z2_12_reg, x3_13_reg, y3_13_reg, z2_13_reg;
    logic signed [TRIG_W-1:0]  cz10_reg, sz10_reg, cz11_reg, sz11_reg;
    logic signed [ROT_W:0]     sum_x2, sum_z2, sum_x3, sum_y3;

    assign sum_x2 = (ROT_W+1)'(p_x0cy_reg) + (ROT_W+1)'(p_z1sy_reg)
                    + (ROT_W+1)'(1 << (Q_FRAC - 1));
    assign sum_z2 = (ROT_W+1)'(p_z1cy_reg) - (ROT_W+1)'(p_x0sy_reg)
                    + (ROT_W+1)'(1 << (Q_FRAC - 1));
    assign sum_x3 = (ROT_W+1)'(q_x2cz_reg) + (ROT_W+1)'(q_y1sz_reg)
                    + (ROT_W+1)'(1 << (Q_FRAC - 1));
    assign sum_y3 = (ROT_W+1)'(q_y1cz_reg) - (ROT_W+1)'(q_x2sz_reg)
                    + (ROT_W+1)'(1 << (Q_FRAC - 1));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_x0cy_reg <= ROT_W'(x0_9_reg) * ROT_W'(cy9_reg);
            p_z1sy_reg <= ROT_W'(z1_9_reg) * ROT_W'(sy9_reg);
            p_z1cy_reg <= ROT_W'(z1_9_reg) * ROT_W'(cy9_reg);
            p_x0sy_reg <= ROT_W'(x0_9_reg) * ROT_W'(sy9_reg);
            y1_10_reg  <= y1_9_reg;
            cz10_reg   <= cz9_reg;
            sz10_reg   <= sz9_reg;
            x2_11_reg  <= COORD_W'(sum_x2 >>> Q_FRAC);
            z2_11_reg  <= COORD_W'(sum_z2 >>> Q_FRAC);
            y1_11_reg  <= y1_10_reg;
            cz11_reg   <= cz10_reg;
            sz11_reg   <= sz10_reg;
            q_x2cz_reg <= ROT_W'(x2_11_reg) * ROT_W'(cz11_reg);
            q_y1sz_reg <= ROT_W'(y1_11_reg) * ROT_W'(sz11_reg);
            q_y1cz_reg <= ROT_W'(y1_11_reg) * ROT_W'(cz11_reg);
            q_x2sz_reg <= ROT_W'(x2_11_reg) * ROT_W'(sz11_reg);
            z2_12_reg  <= z2_11_reg;
            x3_13_reg  <= COORD_W'(sum_x3 >>> Q_FRAC);
            y3_13_reg  <= COORD_W'(sum_y3 >>> Q_FRAC);
            z2_13_reg  <= z2_12_reg;
        end
    end

    // Projection: scaled numerators and the depth denominator, then magnitudes.
    // A quotient that would reach 2^13 is flagged as saturated up front, which
    // also covers a vertex on the eye plane; a zero numerator always gives zero.
    logic signed [NUM_W-1:0] num_x_reg, num_y_reg;
    logic signed [DEN_W-1:0] den_reg;
    logic [DMAG_W-1:0]       dmag;
    div_lane_t               lane_x_next, lane_y_next;
    div_lane_t               lane_x [Q_W+1];
    div_lane_t               lane_y [Q_W+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_x_reg <= NUM_W'(x3_13_reg) * SCALE_S;
            num_y_reg <= NUM_W'(y3_13_reg) * SCALE_S;
            den_reg   <= DEN_W'(z2_13_reg) + EYE_Q15;
        end
    end

    assign dmag = DMAG_W'(den_reg[DEN_W-1] ? -den_reg : den_reg);

    function automatic div_lane_t lane_start(input logic signed [NUM_W-1:0] num,
                                             input logic den_neg,
                                             input logic [DMAG_W-1:0] dm);
        div_lane_t         l;
        logic [NMAG_W-1:0] nm;
        nm     = NMAG_W'(num[NUM_W-1] ? -num : num);
        l.rem  = nm;
        l.dsh  = {dm, (Q_W-1)'(0)};
        l.quo  = '0;
        l.neg  = num[NUM_W-1] ^ den_neg;
        l.sat  = (DSH_W+1)'(nm) >= {dm, Q_W'(0)};
        l.zero = (num == '0);
        return l;
    endfunction

    assign lane_x_next = lane_start(num_x_reg, den_reg[DEN_W-1], dmag);
    assign lane_y_next = lane_start(num_y_reg, den_reg[DEN_W-1], dmag);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_x[0] <= lane_x_next;
            lane_y[0] <= lane_y_next;
        end
    end

    // Divider chain: each cell settles one quotient bit, most significant first.
    for (genvar c = 0; c < Q_W; c++)
    begin : g_chain
        vrp_div_cell u_cell_x (.clk(clk), .en(en), .lane_in(lane_x[c]), .lane_out(lane_x[c+1]));
        vrp_div_cell u_cell_y (.clk(clk), .en(en), .lane_in(lane_y[c]), .lane_out(lane_y[c+1]));
    end

    // Clamp the quotient, apply its sign, add the centre and saturate.
    function automatic logic signed [SCR_W-1:0] lane_finish(input div_lane_t l,
                                                           input logic [CTR_W-1:0] ctr);
        logic [Q_W-1:0]          mag;
        logic signed [Q_W:0]     sq;
        logic signed [Q_W+1:0]   s;
        mag = l.quo;
        if (l.sat || (mag > Q_LIMIT))
        begin
            mag = Q_LIMIT;
        end
        if (l.zero)
        begin
            mag = '0;
        end
        sq = l.neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        s  = (Q_W+2)'(sq) + $signed((Q_W+2)'(ctr));
        if (s > (Q_W+2)'((1 << (SCR_W - 1)) - 1))
        begin
            s = (Q_W+2)'((1 << (SCR_W - 1)) - 1);
        end
        if (s < -$signed((Q_W+2)'(1 << (SCR_W - 1))))
        begin
            s = -$signed((Q_W+2)'(1 << (SCR_W - 1)));
        end
        return SCR_W'(s);
    endfunction

    logic signed [SCR_W-1:0] screen_x_reg, screen_y_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            screen_x_reg <= lane_finish(lane_x[Q_W], center_x_reg);
            screen_y_reg <= lane_finish(lane_y[Q_W], center_y_reg);
        end
    end

    assign screen_x = screen_x_reg;
    assign screen_y = screen_y_reg;

    // A waiting result must hold the input side as well.
    `VRP_ASSERT_NOW(a_stall_holds_input, out_valid && !out_ready, !in_ready, "input taken during stall")
    // An input transfer enters the first stage.
    `VRP_ASSERT_NEXT(a_transfer_enters, in_valid && in_ready, vld_reg[0], "transfer lost at entry")
    // A centre x write lands in its register.
    `VRP_ASSERT_NEXT(a_center_x_write, cfg_valid && (cfg_index == CFG_CENTER_X),
                     center_x_reg == $past(cfg_data), "centre x write lost")

endmodule

// File: design/vrp_sine.sv
// Pipelined Q1.15 sine of a 12-bit angle, seven register stages.
// Depends on vrp_pkg.
module vrp_sine (
    input  logic                                clk,
    input  logic                                en,
    input  logic [vrp_pkg::ANGLE_W-1:0]         angle,
    output logic signed [vrp_pkg::TRIG_W-1:0]   value
);
    import vrp_pkg::*;

    logic [QTR_W:0]   r_ext;
    logic [T_W-1:0]   t_a_reg;
    logic             neg_a_reg;
    logic [2*T_W-1:0] sq;
    logic [T_W-1:0]   t2_reg  [POLY_N+1];
    logic [T_W-1:0]   t_reg   [POLY_N+1];
    logic             neg_reg [POLY_N+1];
    logic [P_W-1:0]   p_reg   [POLY_N+1];
    logic [PROD_W-1:0] prod_d;
    logic [PROD_W-1:0] s_full;
    logic [TRIG_W-1:0] mag;
    logic signed [TRIG_W-1:0] value_reg;

    // Fold the angle into the first quarter wave.
    always_comb
    begin
        r_ext = {1'b0, angle[QTR_W-1:0]};
        if (angle[QTR_W])
        begin
            r_ext = (QTR_W+1)'(1 << QTR_W) - r_ext;
        end
    end

    assign sq = (2*T_W)'(t_a_reg) * (2*T_W)'(t_a_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_a_reg    <= {r_ext, T_SHIFT'(0)};
            neg_a_reg  <= angle[ANGLE_W-1];
            t2_reg[0]  <= T_W'((sq + (2*T_W)'(1 << (Q_FRAC - 1))) >> Q_FRAC);
            t_reg[0]   <= t_a_reg;
            neg_reg[0] <= neg_a_reg;
            p_reg[0]   <= SIN_COEF[0];
        end
    end

    // Horner steps of the odd polynomial, one multiply per stage.
    for (genvar k = 1; k <= POLY_N; k++)
    begin : g_poly
        logic [PROD_W-1:0] prod;
        assign prod = PROD_W'(p_reg[k-1]) * PROD_W'(t2_reg[k-1]);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                p_reg[k]   <= P_W'(PROD_W'(SIN_COEF[k]) - (prod >> Q_FRAC));
                t2_reg[k]  <= t2_reg[k-1];
                t_reg[k]   <= t_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
            end
        end
    end

    assign prod_d = PROD_W'(p_reg[POLY_N]) * PROD_W'(t_reg[POLY_N]);
    assign s_full = (prod_d + PROD_W'(1 << (2*Q_FRAC - 1))) >> (2*Q_FRAC);
    assign mag    = (s_full > PROD_W'(TRIG_MAX)) ? TRIG_MAX : s_full[TRIG_W-1:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            value_reg <= neg_reg[POLY_N] ? -$signed(mag) : $signed(mag);
        end
    end

    assign value = value_reg;

endmodule

// File: design/vrp_div_cell.sv
// One restoring-division cell: settles one quotient bit per cycle while en is high.
// Depends on vrp_pkg.
module vrp_div_cell (
    input  logic               clk,
    input  logic               en,
    input  vrp_pkg::div_lane_t lane_in,
    output vrp_pkg::div_lane_t lane_out
);
    import vrp_pkg::*;

    logic      fits;
    div_lane_t lane_next;
    div_lane_t lane_reg;

    assign fits = DSH_W'(lane_in.rem) >= lane_in.dsh;

    always_comb
    begin
        lane_next     = lane_in;
        lane_next.dsh = lane_in.dsh >> 1;
        lane_next.quo = {lane_in.quo[Q_W-2:0], fits};
        if (fits)
        begin
            lane_next.rem = NMAG_W'(DSH_W'(lane_in.rem) - lane_in.dsh);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;

endmodule
